// ----- hw/rtl/rtt_pkg.sv -----
`timescale 1ns / 1ps

package rtt_pkg;

   localparam int ADDR_W = 16;
   localparam int TTL_W  = 4;

   // Transaction kinds carried on req_action
   typedef enum logic [1:0] {
      ACT_LEARN  = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_FLUSH  = 2'd3
   } action_type;

   // One route held by one cell
   typedef struct packed {
      logic [TTL_W-1:0]  ttl;
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] hop;
   } entry_type;

   // Command broadcast from the controller to every cell
   typedef struct packed {
      logic shift;   // rotate the ring by one cell toward cell 0
      logic tick;    // age every live entry
      logic flush;   // kill every entry
      logic write;   // load the selected cell with the write entry
   } ring_cmd_type;

endpackage

// ----- hw/rtl/rtt_cell.sv -----
`timescale 1ns / 1ps

module rtt_cell
   import rtt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ring_cmd_type cmd,
   input  logic         wr_sel,
   input  entry_type    wr_entry,
   input  entry_type    nb_entry,
   output entry_type    entry
);

   logic [TTL_W-1:0]  ttl_ff;
   logic [ADDR_W-1:0] dest_ff;
   logic [ADDR_W-1:0] hop_ff;

   // Hold the TTL; a write wins over a flush so overflow can seed entry 0
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= '0;
      end else begin
         priority if (cmd.write && wr_sel) begin
            ttl_ff <= wr_entry.ttl;
         end else if (cmd.flush) begin
            ttl_ff <= '0;
         end else if (cmd.tick) begin
            if (ttl_ff != '0) begin
               ttl_ff <= ttl_ff - TTL_W'(1);
            end
         end else if (cmd.shift) begin
            ttl_ff <= nb_entry.ttl;
         end
      end
   end

   // Hold the address payload; no reset needed
   always_ff @(posedge clock) begin
      priority if (cmd.write && wr_sel) begin
         dest_ff <= wr_entry.dest;
         hop_ff  <= wr_entry.hop;
      end else if (cmd.shift) begin
         dest_ff <= nb_entry.dest;
         hop_ff  <= nb_entry.hop;
      end
   end

   assign entry = '{ttl: ttl_ff, dest: dest_ff, hop: hop_ff};

endmodule

// ----- hw/rtl/rtt_ctrl.sv -----
`timescale 1ns / 1ps

module rtt_ctrl
   import rtt_pkg::*;
#(
   parameter  int TABLE_DEPTH = 64,
   localparam int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [ADDR_W-1:0] req_dest_addr,
   input  logic [ADDR_W-1:0] req_next_hop,
   input  logic [TTL_W-1:0]  ttl_start,
   input  entry_type         head,
   output ring_cmd_type      cmd,
   output logic [IDX_W-1:0]  wr_idx,
   output entry_type         wr_entry,
   output logic              rsp_valid,
   output logic              rsp_found,
   output logic [ADDR_W-1:0] rsp_next_hop_out,
   output logic              rsp_overflow
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  count_ff;
   action_type        act_ff;
   logic [ADDR_W-1:0] dest_ff;
   logic [ADDR_W-1:0] hop_ff;
   logic              hit_vld_ff;
   logic [IDX_W-1:0]  hit_idx_ff;
   logic [ADDR_W-1:0] hit_hop_ff;
   logic              dead_vld_ff;
   logic [IDX_W-1:0]  dead_idx_ff;
   logic              rsp_valid_ff;
   logic              rsp_found_ff;
   logic [ADDR_W-1:0] rsp_hop_ff;
   logic              rsp_ovf_ff;

   logic head_live;
   logic head_match;
   logic table_full;

   assign head_live  = (head.ttl != '0);
   assign head_match = head_live && (head.dest == dest_ff);
   assign table_full = !hit_vld_ff && !dead_vld_ff;

   // Drive the ring: rotate while scanning, then apply the update
   always_comb begin
      cmd    = '0;
      wr_idx = '0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN: begin
            cmd.shift = 1'b1;
         end
         ST_APPLY: begin
            unique case (act_ff)
               ACT_LEARN: begin
                  cmd.write = 1'b1;
                  cmd.flush = table_full;
                  priority if (hit_vld_ff) begin
                     wr_idx = hit_idx_ff;
                  end else if (dead_vld_ff) begin
                     wr_idx = dead_idx_ff;
                  end else begin
                     wr_idx = '0;
                  end
               end
               ACT_LOOKUP: begin
               end
               ACT_TICK: begin
                  cmd.tick = 1'b1;
               end
               ACT_FLUSH: begin
                  cmd.flush = 1'b1;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   assign wr_entry = '{ttl: ttl_start, dest: dest_ff, hop: hop_ff};

   // Sequence one transaction and register its response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hit_vld_ff   <= 1'b0;
         dead_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  act_ff      <= action_type'(req_action);
                  dest_ff     <= req_dest_addr;
                  hop_ff      <= req_next_hop;
                  count_ff    <= '0;
                  hit_vld_ff  <= 1'b0;
                  dead_vld_ff <= 1'b0;
                  if (action_type'(req_action) == ACT_LEARN ||
                      action_type'(req_action) == ACT_LOOKUP) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_APPLY;
                  end
               end
            end
            ST_SCAN: begin
               // Record the first live match and the first dead entry
               if (head_match && !hit_vld_ff) begin
                  hit_vld_ff <= 1'b1;
                  hit_idx_ff <= count_ff;
                  hit_hop_ff <= head.hop;
               end
               if (!head_live && !dead_vld_ff) begin
                  dead_vld_ff <= 1'b1;
                  dead_idx_ff <= count_ff;
               end
               count_ff <= count_ff + IDX_W'(1);
               if (count_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= 1'b0;
               rsp_hop_ff   <= '0;
               rsp_ovf_ff   <= 1'b0;
               unique case (act_ff)
                  ACT_LEARN: begin
                     rsp_found_ff <= hit_vld_ff;
                     rsp_ovf_ff   <= table_full;
                  end
                  ACT_LOOKUP: begin
                     rsp_found_ff <= hit_vld_ff;
                     rsp_hop_ff   <= hit_vld_ff ? hit_hop_ff : '0;
                  end
                  ACT_TICK: begin
                  end
                  ACT_FLUSH: begin
                  end
                  default: begin
                  end
               endcase
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_next_hop_out = rsp_hop_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

// ----- hw/rtl/ttl_route_table.sv -----
`timescale 1ns / 1ps
// Channel    Ports                                         Handshake
// request    req_action, req_dest_addr, req_next_hop       start high, busy low
// response   rsp_found, rsp_next_hop_out, rsp_overflow     rsp_valid, one cycle
// register   csr_wr_data (ttl_start)                       csr_wr_en
//
// Learn and lookup scan every cell and then apply before the next accept:
// the entry ring rotates one cell per cycle past the compare at cell 0.
// Tick and flush skip the scan and act on every cell at once.
// Reset clears every TTL and sets ttl_start to 3; no clearing pass.
// The response is shown for one cycle and cannot be stalled by the receiver.

module ttl_route_table
   import rtt_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [ADDR_W-1:0] req_dest_addr,
   input  logic [ADDR_W-1:0] req_next_hop,
   output logic              rsp_valid,
   output logic              rsp_found,
   output logic [ADDR_W-1:0] rsp_next_hop_out,
   output logic              rsp_overflow,
   input  logic              csr_wr_en,
   input  logic [TTL_W-1:0]  csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [TTL_W-1:0] ttl_start_ff;
   ring_cmd_type     cmd;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_entry;
   entry_type        ring [TABLE_DEPTH];

   // Hold the configured start TTL
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_start_ff <= TTL_W'(3);
      end else if (csr_wr_en) begin
         ttl_start_ff <= csr_wr_data;
      end
   end

   rtt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_dest_addr    (req_dest_addr),
      .req_next_hop     (req_next_hop),
      .ttl_start        (ttl_start_ff),
      .head             (ring[0]),
      .cmd              (cmd),
      .wr_idx           (wr_idx),
      .wr_entry         (wr_entry),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_next_hop_out (rsp_next_hop_out),
      .rsp_overflow     (rsp_overflow)
   );

   // Build the ring: each cell loads from its upper neighbor, the last wraps to 0
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rtt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .wr_sel   (wr_idx == IDX_W'(i)),
         .wr_entry (wr_entry),
         .nb_entry (ring[(i + 1) % TABLE_DEPTH]),
         .entry    (ring[i])
      );
   end

   // A response never reports both a refresh and an overflow
   a_found_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_overflow))
      else $error("found and overflow both set");

   // A nonzero next hop comes only with a hit
   a_hop_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_next_hop_out != '0) |-> rsp_found)
      else $error("next hop reported without a hit");

   // An accepted transaction makes the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accept did not raise busy");

   // Responses are never issued in consecutive cycles
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

endmodule
